// ===== rtl/ipv4p_pkg.sv =====
// ----------------------------------------------------------------------------
// ipv4p_pkg
// shared types and constants for the ipv4 dotted text parser
// ----------------------------------------------------------------------------
package ipv4p_pkg;

    localparam int MID_DEPTH_DEF = 2;
    localparam int OUT_DEPTH_DEF = 2;

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;

    localparam logic [8:0] FIELD_LIMIT = 9'd256;
    localparam logic [2:0] MAX_FIELDS  = 3'd4;

    typedef struct packed {
        logic [7:0] ch;
        logic       is_end;
    } t_in_item;

    typedef struct packed {
        logic [31:0] address;
        logic        ok;
    } t_result;

    // classified character
    typedef struct packed {
        logic       is_end;
        logic       is_dot;
        logic       is_zero;
        logic       is_x;
        logic       is_oct;
        logic       is_dec;
        logic       is_hex;
        logic [3:0] digit;
    } t_token;

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_ZERO  = 3'd1,
        PH_XPFX  = 3'd2,
        PH_HEX   = 3'd3,
        PH_OCT   = 3'd4,
        PH_DEC   = 3'd5
    } t_phase;

    typedef enum logic [3:0] {
        ACT_IGNORE,
        ACT_CLOSE,
        ACT_FAIL,
        ACT_ACC8,
        ACT_ACC10,
        ACT_ACC16,
        ACT_ZERO,
        ACT_XPFX,
        ACT_END
    } t_action;

endpackage

// ===== rtl/ipv4p_fifo.sv =====
// ----------------------------------------------------------------------------
// ipv4p_fifo
// small register queue with push/full and pop/empty
// ----------------------------------------------------------------------------
module ipv4p_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] i_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] o_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;
    logic             do_push;
    logic             do_pop;

    assign full    = (r_cnt == CW'(DEPTH));
    assign empty   = (r_cnt == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign o_data  = r_mem[r_rd];

    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] p);
        f_next = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= f_next(r_wr);
            if (do_pop)  r_rd <= f_next(r_rd);
            if (do_push && !do_pop)      r_cnt <= r_cnt + 1'b1;
            else if (do_pop && !do_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_data;
    end

endmodule

// ===== rtl/ipv4p_front.sv =====
// ----------------------------------------------------------------------------
// ipv4p_front
// input register and character classifier, feeds the token queue
// ----------------------------------------------------------------------------
module ipv4p_front import ipv4p_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     push,
    input  t_in_item i_item,
    output logic     full,
    output logic     o_tok_push,
    output t_token   o_tok,
    input  logic     i_tok_full
);

    logic   r_valid;
    t_token r_tok;
    t_token n_tok;
    logic   take;
    logic   is_num;
    logic   is_lo;
    logic   is_up;

    assign full       = r_valid && i_tok_full;
    assign take       = push && !full;
    assign o_tok_push = r_valid;
    assign o_tok      = r_tok;

    always_comb begin
        is_num          = (i_item.ch >= CH_ZERO) && (i_item.ch <= CH_NINE);
        is_lo           = (i_item.ch >= CH_LO_A) && (i_item.ch <= CH_LO_F);
        is_up           = (i_item.ch >= CH_UP_A) && (i_item.ch <= CH_UP_F);
        n_tok.is_end    = i_item.is_end;
        n_tok.is_dot    = (i_item.ch == CH_DOT);
        n_tok.is_zero   = (i_item.ch == CH_ZERO);
        n_tok.is_x      = (i_item.ch == CH_LO_X) || (i_item.ch == CH_UP_X);
        n_tok.is_oct    = (i_item.ch >= CH_ZERO) && (i_item.ch <= CH_SEVEN);
        n_tok.is_dec    = is_num;
        n_tok.is_hex    = is_num || is_lo || is_up;
        // letters a..f map to 10..15 from the low nibble
        n_tok.digit     = is_num ? i_item.ch[3:0] : i_item.ch[3:0] + 4'd9;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (!i_tok_full) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) r_tok <= n_tok;
    end

endmodule

// ===== rtl/ipv4p_back.sv =====
// ----------------------------------------------------------------------------
// ipv4p_back
// field parser state and address assembly, one token per cycle unless stalled
// ----------------------------------------------------------------------------
module ipv4p_back import ipv4p_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_token  i_tok,
    input  logic    i_tok_empty,
    output logic    o_tok_pop,
    output logic    o_res_push,
    output t_result o_res,
    input  logic    i_res_full
);

    t_phase      r_phase;
    t_phase      n_phase;
    logic [8:0]  r_value;
    logic [8:0]  n_value;
    logic [2:0]  r_count;
    logic [2:0]  n_count;
    logic [7:0]  r_bytes [4];
    logic [7:0]  n_bytes [4];
    logic        r_failed;
    logic        n_failed;
    logic        r_finished;
    logic        n_finished;

    t_action     act;
    logic        step;
    logic        close_bad;
    logic [12:0] acc;
    logic [8:0]  acc_sat;
    logic [7:0]  fb [4];
    logic [2:0]  fin_count;
    logic        fin_fail;
    logic        res_ok;
    logic [31:0] res_addr;

    assign step       = !i_tok_empty && (!i_tok.is_end || !i_res_full);
    assign o_tok_pop  = step;
    assign o_res_push = step && i_tok.is_end;
    assign close_bad  = (r_value >= FIELD_LIMIT);

    // action decode
    always_comb begin
        if (i_tok.is_end) begin
            act = ACT_END;
        end else if (r_failed || r_finished) begin
            act = ACT_IGNORE;
        end else if (i_tok.is_dot && r_phase != PH_XPFX) begin
            act = ACT_CLOSE;
        end else begin
            unique case (r_phase)
                PH_START: act = i_tok.is_zero ? ACT_ZERO :
                                i_tok.is_dec  ? ACT_ACC10 : ACT_FAIL;
                PH_ZERO:  act = i_tok.is_x    ? ACT_XPFX :
                                i_tok.is_oct  ? ACT_ACC8 : ACT_FAIL;
                PH_XPFX,
                PH_HEX:   act = i_tok.is_hex  ? ACT_ACC16 : ACT_FAIL;
                PH_OCT:   act = i_tok.is_oct  ? ACT_ACC8 : ACT_FAIL;
                PH_DEC:   act = i_tok.is_dec  ? ACT_ACC10 : ACT_FAIL;
                default:  act = ACT_FAIL;
            endcase
        end
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (act)
            ACT_ACC8:  n_phase = PH_OCT;
            ACT_ACC10: n_phase = PH_DEC;
            ACT_ACC16: n_phase = PH_HEX;
            ACT_ZERO:  n_phase = PH_ZERO;
            ACT_XPFX:  n_phase = PH_XPFX;
            ACT_CLOSE: n_phase = close_bad ? r_phase : PH_START;
            ACT_END:   n_phase = PH_START;
            default:   n_phase = r_phase;
        endcase
    end

    // digit accumulation, saturating at the field limit
    always_comb begin
        unique case (act)
            ACT_ACC8:  acc = {1'b0, r_value, 3'b000} + 13'(i_tok.digit);
            ACT_ACC16: acc = {r_value[8:0], 4'b0000} + 13'(i_tok.digit);
            default:   acc = {1'b0, r_value, 3'b000} + {3'b000, r_value, 1'b0}
                             + 13'(i_tok.digit);
        endcase
        acc_sat = (acc >= 13'(FIELD_LIMIT)) ? FIELD_LIMIT : acc[8:0];
    end

    // terminator: close the open field and expand short forms
    always_comb begin
        fb        = r_bytes;
        fin_count = r_count;
        fin_fail  = r_failed;
        if (!r_failed && !r_finished && r_phase != PH_START) begin
            if (r_phase == PH_XPFX || close_bad) begin
                fin_fail = 1'b1;
            end else if (r_count < MAX_FIELDS) begin
                fb[r_count[1:0]] = r_value[7:0];
                fin_count        = r_count + 1'b1;
            end
        end
        res_ok = !fin_fail && (fin_count != 3'd0);
        unique case (fb[0][7:6])
            2'b00, 2'b01: begin
                if (fin_count == 3'd3) begin
                    fb[3] = fb[2];
                    fb[2] = fb[1];
                    fb[1] = 8'd0;
                end else if (fin_count == 3'd2) begin
                    fb[3] = fb[1];
                    fb[2] = 8'd0;
                    fb[1] = 8'd0;
                end else if (fin_count != MAX_FIELDS) begin
                    res_ok = 1'b0;
                end
            end
            2'b10: begin
                if (fin_count == 3'd3) begin
                    fb[3] = fb[2];
                    fb[2] = 8'd0;
                end else if (fin_count != MAX_FIELDS) begin
                    res_ok = 1'b0;
                end
            end
            default: ;
        endcase
        res_addr = res_ok ? {fb[0], fb[1], fb[2], fb[3]} : 32'd0;
    end

    assign o_res.address = res_addr;
    assign o_res.ok      = res_ok;

    // field state update
    always_comb begin
        n_value    = r_value;
        n_count    = r_count;
        n_bytes    = r_bytes;
        n_failed   = r_failed;
        n_finished = r_finished;
        unique case (act)
            ACT_ACC8, ACT_ACC10, ACT_ACC16: n_value = acc_sat;
            ACT_FAIL: n_failed = 1'b1;
            ACT_CLOSE: begin
                if (close_bad) begin
                    n_failed = 1'b1;
                end else begin
                    if (r_count < MAX_FIELDS) begin
                        n_bytes[r_count[1:0]] = r_value[7:0];
                        n_count               = r_count + 1'b1;
                    end
                    n_value = 9'd0;
                    if (n_count >= MAX_FIELDS) n_finished = 1'b1;
                end
            end
            ACT_END: begin
                n_value    = 9'd0;
                n_count    = 3'd0;
                n_bytes    = '{default: 8'd0};
                n_failed   = 1'b0;
                n_finished = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_START;
            r_value    <= 9'd0;
            r_count    <= 3'd0;
            r_bytes    <= '{default: 8'd0};
            r_failed   <= 1'b0;
            r_finished <= 1'b0;
        end else if (step) begin
            r_phase    <= n_phase;
            r_value    <= n_value;
            r_count    <= n_count;
            r_bytes    <= n_bytes;
            r_failed   <= n_failed;
            r_finished <= n_finished;
        end
    end

endmodule

// ===== rtl/ipv4_dotted_text_parser_top.sv =====
// ----------------------------------------------------------------------------
// ipv4_dotted_text_parser_top
// parses dotted ipv4 text, one character per request, into a 32-bit address
//
//   channel  | handshake      | payload
//   ---------+----------------+----------------------------------------
//   input    | push / full    | i_item  : ch[7:0], is_end
//   result   | empty / pop    | o_result: address[31:0], ok
//
// one request per cycle while full is low; a result comes out for terminator
// requests only, on the result ports once it has passed the input register,
// the token queue and the parser step into the result queue
// the parser handles one token per cycle; it stops only on a terminator
// while the result queue is full, and the token queue absorbs that stall
// synchronous active-low reset clears all queues and parser state
// ----------------------------------------------------------------------------
module ipv4_dotted_text_parser_top import ipv4p_pkg::*; #(
    parameter int MID_DEPTH = MID_DEPTH_DEF,
    parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     push,
    input  t_in_item i_item,
    output logic     full,
    output logic     empty,
    input  logic     pop,
    output t_result  o_result
);

    // front to token queue
    logic    fr_push;
    t_token  fr_tok;
    logic    tq_full;

    // token queue to back
    t_token  tq_tok;
    logic    tq_empty;
    logic    bk_pop;

    // back to result queue
    logic    bk_push;
    t_result bk_res;
    logic    rq_full;

    // classifier stage
    ipv4p_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .i_item     (i_item),
        .full       (full),
        .o_tok_push (fr_push),
        .o_tok      (fr_tok),
        .i_tok_full (tq_full)
    );

    // decouples classification from parsing
    ipv4p_fifo #(
        .WIDTH ($bits(t_token)),
        .DEPTH (MID_DEPTH)
    ) u_tok_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (fr_push),
        .i_data  (fr_tok),
        .full    (tq_full),
        .pop     (bk_pop),
        .o_data  (tq_tok),
        .empty   (tq_empty)
    );

    // parser and address assembly
    ipv4p_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok       (tq_tok),
        .i_tok_empty (tq_empty),
        .o_tok_pop   (bk_pop),
        .o_res_push  (bk_push),
        .o_res       (bk_res),
        .i_res_full  (rq_full)
    );

    // results wait here until popped
    ipv4p_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (OUT_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (bk_push),
        .i_data  (bk_res),
        .full    (rq_full),
        .pop     (pop),
        .o_data  (o_result),
        .empty   (empty)
    );

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// self-checking run of the ipv4 dotted text parser
//
// address strings go in one character per request, each closed by a
// terminator request; a behavioral parser predicts the address and ok flag
// for every terminator, and each popped result is compared with the oldest
// prediction; both sides pause at random to cover every pipeline phase
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ipv4p_pkg::*;

    localparam int ITEM_TARGET  = 1750;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_GAP      = 17;

    // first-byte class, from the top two bits
    localparam logic [1:0] CLASS_A_LO = 2'b00;
    localparam logic [1:0] CLASS_A_HI = 2'b01;
    localparam logic [1:0] CLASS_B    = 2'b10;

    typedef logic [7:0] t_text [$];

    logic     clk   = 1'b0;
    logic     rst_n = 1'b0;
    logic     push  = 1'b0;
    t_in_item item  = '0;
    logic     pop   = 1'b0;
    logic     full;
    logic     empty;
    t_result  result;

    // parser state as the predictor sees it
    logic [8:0] field_acc;
    logic [2:0] fields_done;
    t_phase     phase;
    logic [7:0] field_bytes [4];
    logic       text_bad;
    logic       text_sealed;

    // predicted results still waiting for the result side
    t_result pending_addrs [$];

    int errors     = 0;
    int items_sent = 0;
    int cycles     = 0;
    int pop_wait   = 0;
    bit in_calm    = 1'b0;
    bit out_calm   = 1'b0;

    ipv4_dotted_text_parser_top u_top (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .push     (push),
        .i_item   (item),
        .full     (full),
        .empty    (empty),
        .pop      (pop),
        .o_result (result)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // parser prediction
    // ------------------------------------------------------------------------

    function automatic int hex_val(logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
        if (c >= CH_LO_A && c <= CH_LO_F) return int'(c - CH_LO_A) + 10;
        if (c >= CH_UP_A && c <= CH_UP_F) return int'(c - CH_UP_A) + 10;
        return -1;
    endfunction

    task automatic clear_parse();
        field_acc   = '0;
        fields_done = '0;
        phase       = PH_START;
        text_bad    = 1'b0;
        text_sealed = 1'b0;
        foreach (field_bytes[i]) field_bytes[i] = '0;
    endtask

    // field value saturates at the limit so long digit runs stay bounded
    task automatic add_digit(int radix, int digit);
        int v;
        v = int'(field_acc) * radix + digit;
        field_acc = (v >= int'(FIELD_LIMIT)) ? FIELD_LIMIT : 9'(v);
    endtask

    task automatic close_number();
        if (field_acc >= FIELD_LIMIT) begin
            text_bad = 1'b1;
            return;
        end
        if (fields_done < MAX_FIELDS) begin
            field_bytes[fields_done] = field_acc[7:0];
            fields_done++;
        end
        field_acc = '0;
        phase     = PH_START;
    endtask

    task automatic track_char(logic [7:0] c);
        int d;
        d = hex_val(c);
        // after a failure or a dot ending the fourth field nothing counts
        if (text_bad || text_sealed) return;
        // a dot right after the hex prefix is a failure, handled below
        if (c == CH_DOT && phase != PH_XPFX) begin
            close_number();
            if (!text_bad && fields_done >= MAX_FIELDS) text_sealed = 1'b1;
            return;
        end
        case (phase)
            PH_START: begin
                if (c == CH_ZERO) begin
                    phase = PH_ZERO;
                end else if (c > CH_ZERO && c <= CH_NINE) begin
                    field_acc = 9'(d);
                    phase     = PH_DEC;
                end else begin
                    text_bad = 1'b1;
                end
            end
            PH_ZERO: begin
                if (c == CH_LO_X || c == CH_UP_X) begin
                    phase = PH_XPFX;
                end else if (c >= CH_ZERO && c <= CH_SEVEN) begin
                    add_digit(8, d);
                    phase = PH_OCT;
                end else begin
                    text_bad = 1'b1;
                end
            end
            PH_XPFX, PH_HEX: begin
                if (d >= 0) begin
                    add_digit(16, d);
                    phase = PH_HEX;
                end else begin
                    text_bad = 1'b1;
                end
            end
            PH_OCT: begin
                if (c >= CH_ZERO && c <= CH_SEVEN) add_digit(8, d);
                else text_bad = 1'b1;
            end
            PH_DEC: begin
                if (c >= CH_ZERO && c <= CH_NINE) add_digit(10, d);
                else text_bad = 1'b1;
            end
            default: text_bad = 1'b1;
        endcase
    endtask

    // terminator: close the open field, expand short forms by class
    task automatic resolve_address(output t_result r);
        logic [7:0] b [4];
        logic       good;
        r = '0;
        if (!text_bad && !text_sealed && phase != PH_START) begin
            if (phase == PH_XPFX) text_bad = 1'b1;
            else close_number();
        end
        if (!text_bad && fields_done != 0) begin
            b    = field_bytes;
            good = 1'b1;
            case (b[0][7:6])
                CLASS_A_LO, CLASS_A_HI: begin
                    if (fields_done == 3) begin
                        b[3] = b[2];
                        b[2] = b[1];
                        b[1] = '0;
                    end else if (fields_done == 2) begin
                        b[3] = b[1];
                        b[2] = '0;
                        b[1] = '0;
                    end else if (fields_done != MAX_FIELDS) begin
                        good = 1'b0;
                    end
                end
                CLASS_B: begin
                    if (fields_done == 3) begin
                        b[3] = b[2];
                        b[2] = '0;
                    end else if (fields_done != MAX_FIELDS) begin
                        good = 1'b0;
                    end
                end
                // class c/d/e: short forms keep zeros in the missing bytes
                default: ;
            endcase
            if (good) begin
                r.address = {b[0], b[1], b[2], b[3]};
                r.ok      = 1'b1;
            end
        end
        clear_parse();
    endtask

    task automatic predict(t_in_item it);
        t_result r;
        if (it.is_end) begin
            resolve_address(r);
            pending_addrs.push_back(r);
        end else begin
            track_char(it.ch);
        end
    endtask

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------

    function automatic int draw_gap();
        case ($urandom_range(0, 3))
            0, 1:    return 0;
            2:       return $urandom_range(1, 3);
            default: return $urandom_range(0, MAX_GAP);
        endcase
    endfunction

    // push stays high between back-to-back requests, so it is only lowered
    // when a gap is actually taken
    task automatic send_request(logic [7:0] c, logic term);
        t_in_item it;
        int       gap;
        it.ch     = c;
        it.is_end = term;
        if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
        gap = in_calm ? 0 : draw_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        do @(posedge clk); while (full);
        predict(it);
        items_sent++;
    endtask

    // terminator carries a random character, which the block must ignore
    task automatic send_text(t_text txt);
        foreach (txt[i]) send_request(txt[i], 1'b0);
        send_request(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic append_str(ref t_text txt, input string s);
        for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
    endtask

    // one number in a random base, hex in mixed case
    function automatic string field_text(int v);
        string s;
        case ($urandom_range(0, 5))
            0: begin
                s = $sformatf("%0h", v);
                for (int i = 0; i < s.len(); i++) begin
                    if (s[i] >= CH_LO_A && s[i] <= CH_LO_F && $urandom_range(0, 1))
                        s[i] = s[i] - (CH_LO_A - CH_UP_A);
                end
                if ($urandom_range(0, 3) == 0) s = {"0", s};
                if ($urandom_range(0, 1)) return {"0x", s};
                return {"0X", s};
            end
            1:       return {"0", $sformatf("%0o", v)};
            default: return $sformatf("%0d", v);
        endcase
    endfunction

    function automatic int draw_byte_value();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 255;
            2:       return $urandom_range(0, 7);
            3:       return $urandom_range(192, 255);
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // well-formed text of one to four parts, sometimes with an empty field,
    // a trailing dot or junk after the fourth field's dot
    task automatic build_address(ref t_text txt);
        int parts;
        case ($urandom_range(0, 9))
            0:       parts = 1;
            1, 2:    parts = 2;
            3, 4:    parts = 3;
            default: parts = 4;
        endcase
        for (int p = 0; p < parts; p++) begin
            if (p > 0) txt.push_back(CH_DOT);
            if ($urandom_range(0, 24) != 0) append_str(txt, field_text(draw_byte_value()));
        end
        if (parts == 4 && $urandom_range(0, 5) == 0) begin
            txt.push_back(CH_DOT);
            repeat ($urandom_range(0, 5)) txt.push_back(8'($urandom_range(0, 255)));
        end else if ($urandom_range(0, 9) == 0) begin
            txt.push_back(CH_DOT);
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // empty text, trailing dot, all three bases, ignored tail after four
    // fields, octal with 8, bare hex prefix, too-large value, class d
    // zero-fill, class b and class a short forms, whitespace, nul and 0xff
    task automatic test_corner_strings();
        string cases [10] = '{"", "1.", "0xFf.0377.9.0.x", "08", "0x", "256",
                              "224.1", "128.1.2", "1.2", " 1"};
        t_text txt;
        foreach (cases[k]) begin
            txt = {};
            append_str(txt, cases[k]);
            send_text(txt);
        end
        send_text('{CH_ZERO, 8'h00});
        send_text('{CH_DOT, 8'hFF});
    endtask

    task automatic test_wellformed_addresses();
        t_text txt;
        while (items_sent < ITEM_TARGET * 6 / 10) begin
            txt = {};
            build_address(txt);
            send_text(txt);
        end
    endtask

    // well-formed text with one defect: a stray or replaced character,
    // an out-of-range field, a bare hex prefix, an 8 or 9 in octal, a sign
    task automatic test_broken_addresses();
        t_text txt;
        int    pos;
        while (items_sent < ITEM_TARGET * 85 / 100) begin
            txt = {};
            build_address(txt);
            pos = $urandom_range(0, txt.size());
            case ($urandom_range(0, 5))
                0: txt.insert(pos, 8'($urandom_range(0, 255)));
                1: if (txt.size() > 0) txt[pos % txt.size()] = 8'($urandom_range(0, 255));
                2: begin
                    txt.push_back(CH_DOT);
                    append_str(txt, field_text($urandom_range(256, 4095)));
                end
                3: append_str(txt, ".0x");
                4: begin
                    if ($urandom_range(0, 1)) append_str(txt, ".08");
                    else append_str(txt, ".019");
                end
                default: txt.push_front($urandom_range(0, 1) ? "-" : "+");
            endcase
            send_text(txt);
        end
    endtask

    // short random runs, biased toward characters the parser cares about
    task automatic test_noise_text();
        string alphabet = "0123456789.xXaAfFgG ";
        t_text txt;
        while (items_sent < ITEM_TARGET) begin
            txt = {};
            repeat ($urandom_range(0, 8)) begin
                if ($urandom_range(0, 2) == 0)
                    txt.push_back(8'($urandom_range(0, 255)));
                else
                    txt.push_back(alphabet[$urandom_range(0, alphabet.len() - 1)]);
            end
            send_text(txt);
        end
    endtask

    // ------------------------------------------------------------------------
    // result side: random pop stalls, compare against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        t_result want;
        if (!rst_n) begin
            pop      <= 1'b0;
            pop_wait = 0;
        end else begin
            if (pop && !empty) begin
                if (pending_addrs.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result: expected none, actual %h ok %b",
                             $time, result.address, result.ok);
                end else begin
                    want = pending_addrs.pop_front();
                    if (result.address !== want.address) begin
                        errors++;
                        $display("%0t: address mismatch: expected %h, actual %h",
                                 $time, want.address, result.address);
                    end
                    if (result.ok !== want.ok) begin
                        errors++;
                        $display("%0t: ok mismatch: expected %b, actual %b",
                                 $time, want.ok, result.ok);
                    end
                end
                if ($urandom_range(0, 29) == 0) out_calm = !out_calm;
                pop_wait = out_calm ? 0 : draw_gap();
            end else if (pop_wait > 0) begin
                pop_wait--;
            end
            pop <= (pop_wait == 0);
        end
    end

    // hard stop in case the block hangs
    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("** ipv4_dotted_text_parser_top: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        clear_parse();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_corner_strings();
        test_wellformed_addresses();
        test_broken_addresses();
        test_noise_text();

        push <= 1'b0;
        while (pending_addrs.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && pending_addrs.size() == 0)
            $display("** ipv4_dotted_text_parser_top: PASSED **");
        else
            $display("** ipv4_dotted_text_parser_top: FAILED **");
        $finish;
    end

endmodule
